// ===== hdl/vrp_pkg.sv =====
// Shared widths, register codes, reset values and helper functions for the vertex transform.
`default_nettype none

package vrp_pkg;

  // Coordinate and coefficient formats.
  localparam int COORD_W   = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int NEAR_W    = 15;
  localparam int DEPTH_W   = 21;
  localparam int REG_W     = 3 * COORD_W;

  // Datapath widths: product, three-term sum, shifted sum and offset-corrected value.
  localparam int PROD_W  = COORD_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SHIFT_W = ACC_W - FRAC_BITS;
  localparam int T_W     = SHIFT_W + 1;

  // Divider widths. For every visible point the quotient is smaller than the undivided value.
  localparam int QUO_W      = T_W - 1;
  localparam int DEN_W      = T_W - 1;
  localparam int NUM_W      = NEAR_W + QUO_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  // Clock edges from the edge that takes a request to the edge that takes its result:
  // multiply, sum, near product, the divider stages and the output register.
  localparam int OUT_LAT = DIV_STAGES + 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 3'd4;

  // Reset values: identity matrix in Q4.12, no offset, near plane at 100.
  localparam logic [REG_W-1:0]  ROW0_RST   = 48'h0000_0000_1000;
  localparam logic [REG_W-1:0]  ROW1_RST   = 48'h0000_1000_0000;
  localparam logic [REG_W-1:0]  ROW2_RST   = 48'h1000_0000_0000;
  localparam logic [REG_W-1:0]  OFFSET_RST = '0;
  localparam logic [NEAR_W-1:0] NEAR_RST   = 15'd100;

  // Per-request values carried alongside the divider.
  typedef struct packed {
    logic                      vis;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] pass_x;
    logic signed [COORD_W-1:0] pass_y;
    logic signed [DEPTH_W-1:0] depth;
  } vrp_side_t;

  // Saturate a transformed value to the screen coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [T_W-1:0] v);
    logic [T_W-COORD_W:0] top;
    logic                 fits;
    top  = v[T_W-1:COORD_W-1];
    fits = (&top) | ~(|top);
    if (fits) begin
      return v[COORD_W-1:0];
    end else if (v[T_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Saturate a transformed value to the depth range.
  function automatic logic signed [DEPTH_W-1:0] sat_depth(input logic signed [T_W-1:0] v);
    logic [T_W-DEPTH_W:0] top;
    logic                 fits;
    top  = v[T_W-1:DEPTH_W-1];
    fits = (&top) | ~(|top);
    if (fits) begin
      return v[DEPTH_W-1:0];
    end else if (v[T_W-1]) begin
      return {1'b1, {(DEPTH_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DEPTH_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vrp_divider.sv =====
// Pipelined restoring divider: unsigned quotient, a fixed number of quotient bits per stage.
`default_nettype none

module vrp_divider import vrp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  // Per stage: partial remainder, numerator bits still to come shifted against
  // quotient bits already found, and the divisor.
  logic [DEN_W-1:0] rem_q  [DIV_STAGES];
  logic [QUO_W-1:0] work_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q  [DIV_STAGES];

  logic [DEN_W-1:0] rem_in  [DIV_STAGES];
  logic [QUO_W-1:0] work_in [DIV_STAGES];
  logic [DEN_W-1:0] den_in  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_d;
    logic [QUO_W-1:0] work_d;

    // The high numerator bits start as the remainder, since they are below the divisor.
    if (s == 0) begin : g_first
      assign rem_in[s]  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign work_in[s] = num_i[QUO_W-1:0];
      assign den_in[s]  = den_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign work_in[s] = work_q[s-1];
      assign den_in[s]  = den_q[s-1];
    end

    // Trial subtractions for this stage's quotient bits.
    always_comb begin
      logic [DEN_W-1:0] r;
      logic [QUO_W-1:0] w;
      logic [DEN_W:0]   trial;
      logic             qbit;
      r = rem_in[s];
      w = work_in[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {r, w[QUO_W-1]};
        if (trial >= {1'b0, den_in[s]}) begin
          r    = DEN_W'(trial - {1'b0, den_in[s]});
          qbit = 1'b1;
        end else begin
          r    = trial[DEN_W-1:0];
          qbit = 1'b0;
        end
        w = {w[QUO_W-2:0], qbit};
      end
      rem_d  = r;
      work_d = w;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      work_q[s] <= work_d;
      den_q[s]  <= den_in[s];
    end
  end

  assign quo_o = work_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/vertex_rotate_project.sv =====
// Top level of the vertex transform: matrix rotation, camera offset and perspective divide.
`default_nettype none

// One point is taken on every clock cycle in which start_i is high; busy_o is never
// raised, so requests may stream back to back. Each result appears on the result ports
// for a single cycle, flagged by done_o; it cannot be held off by the receiver. Each
// request passes through one stage of coefficient multipliers, one stage of row sums and
// offset subtraction, one stage that forms near times x and y, the perspective divide
// (an 11-stage restoring divider that resolves two quotient bits per stage) and one
// output register. Configuration writes are always ready and must only be made while no
// request is in flight.

module vertex_rotate_project import vrp_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Request channel
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic signed [COORD_W-1:0]   point_x_i,
  input  wire logic signed [COORD_W-1:0]   point_y_i,
  input  wire logic signed [COORD_W-1:0]   point_z_i,
  // Result channel
  output logic                             done_o,
  output logic signed [COORD_W-1:0]        screen_x_o,
  output logic signed [COORD_W-1:0]        screen_y_o,
  output logic signed [DEPTH_W-1:0]        depth_o,
  output logic                             visible_o,
  // Configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [REG_W-1:0]     cfg_data_i
);

  logic                accept;
  logic [REG_W-1:0]    row_q [3];
  logic [REG_W-1:0]    offset_q;
  logic [NEAR_W-1:0]   near_q;

  logic signed [COORD_W-1:0] point [3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [T_W-1:0]     t_d [3];
  logic signed [T_W-1:0]     t_q [3];

  logic                s1_valid_q;
  logic                s2_valid_q;
  logic                s3_valid_q;
  logic [DIV_STAGES-1:0] dly_valid_q;
  logic                done_q;

  vrp_side_t           s3_side_d;
  vrp_side_t           s3_side_q;
  vrp_side_t           dly_side_q [DIV_STAGES];
  logic [NUM_W-1:0]    num_x_d;
  logic [NUM_W-1:0]    num_x_q;
  logic [NUM_W-1:0]    num_y_d;
  logic [NUM_W-1:0]    num_y_q;
  logic [DEN_W-1:0]    den_q;
  logic [QUO_W-1:0]    quo_x;
  logic [QUO_W-1:0]    quo_y;

  logic signed [COORD_W-1:0] screen_x_d;
  logic signed [COORD_W-1:0] screen_y_d;
  logic signed [COORD_W-1:0] screen_x_q;
  logic signed [COORD_W-1:0] screen_y_q;
  logic signed [DEPTH_W-1:0] depth_q;
  logic                      visible_q;

  // The pipeline never stalls, so every request is taken.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      offset_q <= OFFSET_RST;
      near_q   <= NEAR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW0:   row_q[0] <= cfg_data_i;
        CFG_ROW1:   row_q[1] <= cfg_data_i;
        CFG_ROW2:   row_q[2] <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_NEAR:   near_q   <= cfg_data_i[NEAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Valid bits travel alongside the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      dly_valid_q <= '0;
      done_q      <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      dly_valid_q <= {dly_valid_q[DIV_STAGES-2:0], s3_valid_q};
      done_q      <= dly_valid_q[DIV_STAGES-1];
    end
  end

  // Stage 1: the nine coefficient products.
  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PROD_W'($signed(row_q[r][COEF_W*c +: COEF_W]) * point[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Stage 2: row sums, floor shift of the fraction bits and camera offset.
  always_comb begin
    logic signed [ACC_W-1:0]   acc;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [COORD_W-1:0] off;
    for (int r = 0; r < 3; r++) begin
      acc     = ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1]) + ACC_W'(prod_q[r][2]);
      shifted = acc[ACC_W-1:FRAC_BITS];
      off     = $signed(offset_q[COORD_W*r +: COORD_W]);
      t_d[r]  = T_W'(shifted) - T_W'(off);
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  // Stage 3: visibility test and near times the magnitudes of x and y.
  always_comb begin
    logic [T_W-1:0]        abs_x;
    logic [T_W-1:0]        abs_y;
    logic [NEAR_W+T_W-1:0] nx;
    logic [NEAR_W+T_W-1:0] ny;
    abs_x = t_q[0][T_W-1] ? T_W'(-t_q[0]) : t_q[0];
    abs_y = t_q[1][T_W-1] ? T_W'(-t_q[1]) : t_q[1];
    nx    = near_q * abs_x;
    ny    = near_q * abs_y;
    num_x_d = nx[NUM_W-1:0];
    num_y_d = ny[NUM_W-1:0];

    s3_side_d.vis    = t_q[2] > $signed({{(T_W-NEAR_W){1'b0}}, near_q});
    s3_side_d.neg_x  = t_q[0][T_W-1];
    s3_side_d.neg_y  = t_q[1][T_W-1];
    s3_side_d.pass_x = sat_coord(t_q[0]);
    s3_side_d.pass_y = sat_coord(t_q[1]);
    s3_side_d.depth  = sat_depth(t_q[2]);
  end

  always_ff @(posedge clk_i) begin
    num_x_q   <= num_x_d;
    num_y_q   <= num_y_d;
    den_q     <= t_q[2][DEN_W-1:0];
    s3_side_q <= s3_side_d;
  end

  // Divide stages: quotients of near*x and near*y by the depth.
  vrp_divider u_div_x (
    .clk_i (clk_i),
    .num_i (num_x_q),
    .den_i (den_q),
    .quo_o (quo_x)
  );

  vrp_divider u_div_y (
    .clk_i (clk_i),
    .num_i (num_y_q),
    .den_i (den_q),
    .quo_o (quo_y)
  );

  // Side values wait alongside the divider.
  always_ff @(posedge clk_i) begin
    dly_side_q[0] <= s3_side_q;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly_side_q[i] <= dly_side_q[i-1];
    end
  end

  // Output stage: restore the sign, saturate, and pick projected or plain values.
  always_comb begin
    logic signed [T_W-1:0] proj_x;
    logic signed [T_W-1:0] proj_y;
    vrp_side_t             side;
    side   = dly_side_q[DIV_STAGES-1];
    proj_x = side.neg_x ? T_W'(-$signed({1'b0, quo_x})) : $signed({1'b0, quo_x});
    proj_y = side.neg_y ? T_W'(-$signed({1'b0, quo_y})) : $signed({1'b0, quo_y});
    screen_x_d = side.vis ? sat_coord(proj_x) : side.pass_x;
    screen_y_d = side.vis ? sat_coord(proj_y) : side.pass_y;
  end

  always_ff @(posedge clk_i) begin
    screen_x_q <= screen_x_d;
    screen_y_q <= screen_y_d;
    depth_q    <= dly_side_q[DIV_STAGES-1].depth;
    visible_q  <= dly_side_q[DIV_STAGES-1].vis;
  end

  assign done_o     = done_q;
  assign screen_x_o = screen_x_q;
  assign screen_y_o = screen_y_q;
  assign depth_o    = depth_q;
  assign visible_o  = visible_q;

`ifndef SYNTHESIS
  // Every request yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##OUT_LAT done_o)
    else $error("request did not produce a result after the pipeline latency");

  // No result appears without a request having passed the multiply stages.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s3_valid_q, DIV_STAGES + 1))
    else $error("result strobe without a matching request");

  // A projected point always lies in front of the camera.
  a_vis_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && visible_o) |-> (depth_o > 0))
    else $error("visible result with non-positive depth");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the vertex rotate, offset and perspective projection block.
`timescale 1ns / 100ps

module tb;
  import vrp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 11;
  localparam int PHASE_POINTS = 150;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // One expected screen point.
  typedef struct {
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic signed [DEPTH_W-1:0] depth;
    logic                      visible;
  } screen_point_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start_i     = 1'b0;
  logic signed [COORD_W-1:0]  point_x_i   = '0;
  logic signed [COORD_W-1:0]  point_y_i   = '0;
  logic signed [COORD_W-1:0]  point_z_i   = '0;
  logic                       cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_ROW0;
  logic [REG_W-1:0]           cfg_data_i  = '0;
  logic                       busy_o;
  logic                       done_o;
  logic signed [COORD_W-1:0]  screen_x_o;
  logic signed [COORD_W-1:0]  screen_y_o;
  logic signed [DEPTH_W-1:0]  depth_o;
  logic                       visible_o;
  logic                       cfg_ready_o;

  // Local copy of the configuration, updated as each write is accepted.
  logic [REG_W-1:0]  matrix_rows [3] = '{ROW0_RST, ROW1_RST, ROW2_RST};
  logic [REG_W-1:0]  offset_reg      = OFFSET_RST;
  logic [NEAR_W-1:0] near_reg        = NEAR_RST;

  screen_point_t projected_q [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            steady_left    = 0;

  vertex_rotate_project DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .done_o      (done_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .depth_o     (depth_o),
    .visible_o   (visible_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Signed 16-bit field j of a packed register.
  function automatic longint field_of(logic [REG_W-1:0] packed_reg, int j);
    logic signed [COEF_W-1:0] f;
    f = packed_reg[16*j +: 16];
    return f;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Rotate, offset and project one point under the current configuration.
  function automatic screen_point_t project_point(logic signed [COORD_W-1:0] px,
                                                  logic signed [COORD_W-1:0] py,
                                                  logic signed [COORD_W-1:0] pz);
    longint        p [3];
    longint        t [3];
    longint        acc;
    longint        near_l;
    screen_point_t r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      acc = field_of(matrix_rows[i], 0) * p[0] + field_of(matrix_rows[i], 1) * p[1]
          + field_of(matrix_rows[i], 2) * p[2];
      // The arithmetic shift of a signed sum rounds towards minus infinity.
      t[i] = (acc >>> FRAC_BITS) - field_of(offset_reg, i);
    end
    near_l    = near_reg;
    r.visible = t[2] > near_l;
    if (r.visible) begin
      t[0] = (near_l * t[0]) / t[2];
      t[1] = (near_l * t[1]) / t[2];
    end
    r.screen_x = COORD_W'(clamp(t[0], COORD_W));
    r.screen_y = COORD_W'(clamp(t[1], COORD_W));
    r.depth    = DEPTH_W'(clamp(t[2], DEPTH_W));
    return r;
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Compare each result strobe with the oldest expected screen point.
  always @(posedge clk_i) begin
    screen_point_t want;
    if (rst_ni && done_o) begin
      if (projected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d depth=%0d visible=%0b", $time,
                 screen_x_o, screen_y_o, depth_o, visible_o);
        mismatch_count++;
      end else begin
        want = projected_q.pop_front();
        if (screen_x_o !== want.screen_x) begin
          $display("%0t: screen_x expected %0d, got %0d", $time, want.screen_x, screen_x_o);
          mismatch_count++;
        end
        if (screen_y_o !== want.screen_y) begin
          $display("%0t: screen_y expected %0d, got %0d", $time, want.screen_y, screen_y_o);
          mismatch_count++;
        end
        if (depth_o !== want.depth) begin
          $display("%0t: depth expected %0d, got %0d", $time, want.depth, depth_o);
          mismatch_count++;
        end
        if (visible_o !== want.visible) begin
          $display("%0t: visible expected %0b, got %0b", $time, want.visible, visible_o);
          mismatch_count++;
        end
      end
    end
  end

  // Send one point after a random gap, and record its expected result once taken.
  task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                            logic signed [COORD_W-1:0] pz);
    int gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      steady_left = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    do @(posedge clk_i); while (busy_o);
    projected_q.push_back(project_point(px, py, pz));
  endtask

  // Stop sending and wait until every outstanding request has returned.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (projected_q.size() != 0);
  endtask

  // Write one register; the valid stays high for a following write.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROW0:   matrix_rows[0] = data;
      CFG_ROW1:   matrix_rows[1] = data;
      CFG_ROW2:   matrix_rows[2] = data;
      CFG_OFFSET: offset_reg     = data;
      CFG_NEAR:   near_reg       = data[NEAR_W-1:0];
      default: ;
    endcase
  endtask

  // Load a full configuration once the pipeline is empty.
  task automatic apply_config(logic [REG_W-1:0] r0, logic [REG_W-1:0] r1,
                              logic [REG_W-1:0] r2, logic [REG_W-1:0] off,
                              logic [REG_W-1:0] near_val);
    wait_drained();
    write_register(CFG_ROW0, r0);
    write_register(CFG_ROW1, r1);
    write_register(CFG_ROW2, r2);
    write_register(CFG_OFFSET, off);
    write_register(CFG_NEAR, near_val);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] random_coef(int unsigned style);
    case (style)
      0: return COEF_W'($urandom);
      1: return COEF_W'($urandom_range(0, 8192) - 4096);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'h1000;
          default: return 16'hF000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_coord(int unsigned style);
    case (style)
      0, 1: return COORD_W'($urandom);
      2:    return COORD_W'($urandom_range(0, 600) - 300);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
    endcase
  endfunction

  // Default identity matrix: depth against the near plane, clipping and projection.
  task automatic test_reset_identity();
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd32767, -16'sd32768, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767, -16'sd32768);
    send_point(16'sd100, 16'sd50, 16'sd100);
    send_point(16'sd100, 16'sd50, 16'sd101);
  endtask

  // Largest and most negative coefficients and offsets, with the near plane at both ends.
  task automatic test_extreme_matrix();
    apply_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                 {16'h8000, 16'h8000, 16'h7FFF}, 48'd32767);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    apply_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                 {16'h7FFF, 16'h7FFF, 16'h8000}, 48'd1);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
  endtask

  // Tiny coefficients, so that negative row sums show the rounding towards minus infinity.
  task automatic test_floor_shift();
    apply_config(48'h0000_0000_0001, 48'h0000_FFFF_0000, ROW2_RST, OFFSET_RST, 48'd100);
    send_point(-16'sd1, 16'sd1, 16'sd0);
    send_point(16'sd4095, -16'sd4097, 16'sd50);
    send_point(-16'sd4097, 16'sd4095, 16'sd200);
  endtask

  // Near distance of zero; the upper data bits must be dropped by the near register.
  task automatic test_near_zero();
    apply_config(ROW0_RST, ROW1_RST, ROW2_RST, OFFSET_RST, 48'hFFFF_FFFF_8000);
    send_point(16'sd50, -16'sd50, 16'sd1);
    send_point(16'sd7, 16'sd7, 16'sd0);
    send_point(16'sd7, 16'sd7, -16'sd1);
  endtask

  // Writes to undecoded indexes must leave the configuration alone.
  task automatic test_unknown_index();
    wait_drained();
    for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++) begin
      write_register(i[CFG_IDX_W-1:0], REG_W'({$urandom, $urandom}));
    end
    cfg_valid_i <= 1'b0;
    send_point(16'sd300, -16'sd200, 16'sd500);
    send_point(-16'sd300, 16'sd200, 16'sd5);
  endtask

  // Random configurations, each followed by a stream of random points.
  task automatic test_random_stream();
    int unsigned      style;
    logic [REG_W-1:0] rows [3];
    logic [REG_W-1:0] off;
    logic [REG_W-1:0] near_val;
    for (int phase = 0; phase < PHASES; phase++) begin
      style = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        rows[i] = {random_coef(style), random_coef(style), random_coef(style)};
      end
      case ($urandom_range(0, 2))
        0: off = '0;
        1: off = REG_W'({$urandom, $urandom});
        default: off = {random_coord(2), random_coord(2), random_coord(2)};
      endcase
      if (phase == 0) begin
        near_val = 48'd1;
      end else if (phase == 1) begin
        near_val = 48'd32767;
      end else if ($urandom_range(0, 1) == 0) begin
        near_val = REG_W'($urandom_range(1, 200));
      end else begin
        near_val = REG_W'($urandom_range(1, 32767));
      end
      apply_config(rows[0], rows[1], rows[2], off, near_val);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        // Halfway through the first phase the sender holds off until the pipeline empties.
        if (phase == 0 && n == PHASE_POINTS / 2) begin
          wait_drained();
        end
        style = $urandom_range(0, 4);
        send_point(random_coord(style), random_coord(style), random_coord(style));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_identity();
    test_extreme_matrix();
    test_floor_shift();
    test_near_zero();
    test_unknown_index();
    test_random_stream();
    wait_drained();
    repeat (OUT_LAT + 4) @(posedge clk_i);
    if (mismatch_count == 0 && projected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
